### src/csd_pkg.sv
`timescale 1ns / 1ps

package csd_pkg;

  localparam int PHASE_COUNT = 3;

  localparam int PADDR_W = 6;
  localparam int PDATA_W = 64;
  localparam int S_TDATA_W = 208;
  localparam int M_TDATA_W = 96;

  localparam logic [47:0] POS48 = 48'h7fff_ffff_ffff;
  localparam logic [47:0] NEG48 = 48'h8000_0000_0000;

  localparam logic [47:0] INV_L_RESET = 48'd6553600000;
  localparam logic [47:0] INV_C_RESET = 48'd655360000;

  localparam logic MODE_BOOST = 1'b0;
  localparam logic MODE_BUCK  = 1'b1;

  typedef enum logic [2:0] {
    REG_MODE    = 3'd0,
    REG_INV_L_A = 3'd1,
    REG_INV_L_B = 3'd2,
    REG_INV_L_C = 3'd3,
    REG_INV_C   = 3'd4
  } reg_idx_t;

  // datapath micro-operations, issued one per cycle by the controller
  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_INIT   = 4'd1,
    OP_T1     = 4'd2,
    OP_T2     = 4'd3,
    OP_RND    = 4'd4,
    OP_ACC    = 4'd5,
    OP_W0     = 4'd6,
    OP_W1     = 4'd7,
    OP_W2     = 4'd8,
    OP_W3     = 4'd9,
    OP_W4     = 4'd10,
    OP_FIN_I  = 4'd11,
    OP_VLOAD  = 4'd12,
    OP_FIN_V  = 4'd13
  } op_t;

  typedef struct packed {
    logic        mode;
    logic [47:0] inv_l_a;
    logic [47:0] inv_l_b;
    logic [47:0] inv_l_c;
    logic [47:0] inv_c;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         phase;
    logic               last;
    logic signed [31:0] vin;
    logic signed [31:0] vout;
    logic signed [31:0] iout;
    logic signed [31:0] il;
    logic [16:0]        duty;
    logic [30:0]        rl;
    logic signed [31:0] vd;
  } item_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [47:0] islope;
    logic [47:0] vslope;
    logic        last;
    logic        sat;
  } res_t;

  typedef struct packed {
    op_t  op;
    logic capture;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic phase_ok;
    logic last;
  } stat_t;

endpackage

### src/csd_regs.sv
`timescale 1ns / 1ps

module csd_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [csd_pkg::PADDR_W-1:0] paddr,
  input  logic [csd_pkg::PDATA_W-1:0] pwdata,
  output logic [csd_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output csd_pkg::cfg_t               cfg
);
  import csd_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[5:3]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode    <= MODE_BOOST;
      cfg.inv_l_a <= INV_L_RESET;
      cfg.inv_l_b <= INV_L_RESET;
      cfg.inv_l_c <= INV_L_RESET;
      cfg.inv_c   <= INV_C_RESET;
    end else if (wr) begin
      unique case (idx)
        REG_MODE:    cfg.mode    <= pwdata[0];
        REG_INV_L_A: cfg.inv_l_a <= pwdata[47:0];
        REG_INV_L_B: cfg.inv_l_b <= pwdata[47:0];
        REG_INV_L_C: cfg.inv_l_c <= pwdata[47:0];
        REG_INV_C:   cfg.inv_c   <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE:    prdata = {63'b0, cfg.mode};
      REG_INV_L_A: prdata = {16'b0, cfg.inv_l_a};
      REG_INV_L_B: prdata = {16'b0, cfg.inv_l_b};
      REG_INV_L_C: prdata = {16'b0, cfg.inv_l_c};
      REG_INV_C:   prdata = {16'b0, cfg.inv_c};
      default:     prdata = '0;
    endcase
  end

endmodule

### src/csd_ctrl.sv
`timescale 1ns / 1ps

module csd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  csd_pkg::stat_t stat,
  output csd_pkg::cmd_t  cmd
);
  import csd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_RUN   = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t state, state_next;
  op_t    op, op_next;
  logic   vpass, vpass_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    op_next      = op;
    vpass_next   = vpass;
    cmd.op       = OP_NONE;
    cmd.capture  = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        // an item for a phase that does not exist leaves no trace
        if (stat.phase_ok) begin
          state_next = S_RUN;
          op_next    = OP_INIT;
          vpass_next = 1'b0;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_RUN: begin
        cmd.op = op;
        unique case (op)
          OP_INIT:  op_next = OP_T1;
          OP_T1:    op_next = OP_T2;
          OP_T2:    op_next = OP_RND;
          OP_RND:   op_next = OP_ACC;
          OP_ACC:   op_next = OP_W0;
          OP_W0:    op_next = OP_W1;
          OP_W1:    op_next = OP_W2;
          OP_W2:    op_next = OP_W3;
          OP_W3:    op_next = OP_W4;
          OP_W4:    op_next = vpass ? OP_FIN_V : OP_FIN_I;
          OP_FIN_I: begin
            if (stat.last) begin
              op_next = OP_VLOAD;
            end else begin
              state_next = S_OUT;
            end
          end
          OP_VLOAD: begin
            op_next    = OP_W0;
            vpass_next = 1'b1;
          end
          OP_FIN_V: state_next = S_OUT;
          default:  state_next = S_IDLE;
        endcase
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= OP_NONE;
      vpass     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      op    <= op_next;
      vpass <= vpass_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken result");

  a_accept_check: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_CHECK))
    else $error("accepted transfer not followed by phase check");

  a_vpass_fin: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && op == OP_FIN_V) |-> vpass)
    else $error("voltage finish outside the voltage pass");

  a_vload_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && op == OP_VLOAD) |-> stat.last)
    else $error("voltage pass started for a non-last phase");

  a_out_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.load_out))
    else $error("output valid rose without a load");

endmodule

### src/csd_dp.sv
`timescale 1ns / 1ps

module csd_dp (
  input  logic           clk,
  input  logic           rst,
  input  csd_pkg::cmd_t  cmd,
  output csd_pkg::stat_t stat,
  input  csd_pkg::cfg_t  cfg,
  input  csd_pkg::item_t in_item,
  output csd_pkg::res_t  res
);
  import csd_pkg::*;

  item_t              item;
  logic signed [17:0] omd;
  logic signed [32:0] vod;
  logic signed [32:0] vid;
  logic signed [63:0] vod64;
  logic signed [63:0] vin64;
  logic signed [33:0] ma;
  logic signed [33:0] mb;
  logic signed [67:0] prod;
  logic signed [63:0] prod64;
  logic signed [63:0] num;
  logic [63:0]        nmag;
  logic [67:0]        pmag;
  logic [33:0]        pround;
  logic signed [34:0] contrib;
  logic signed [34:0] contrib_next;
  logic signed [47:0] sum;
  logic signed [48:0] sum_add;
  logic signed [48:0] dv;
  logic [48:0]        dmag;
  logic [63:0]        wa;
  logic [47:0]        wb;
  logic               wneg;
  logic [111:0]       wacc;
  logic [47:0]        inv_l;
  logic               fin_v;
  logic [112:0]       rsum;
  logic [112:0]       rshift;
  logic [112:0]       rlim;
  logic               rover;
  logic [47:0]        rval;
  logic [47:0]        islope;
  logic [47:0]        vslope;
  logic               sat;

  assign stat.phase_ok = (item.phase < 2'(PHASE_COUNT));
  assign stat.last     = item.last;

  assign omd    = 18'sh10000 - $signed({1'b0, item.duty});
  assign vod    = {item.vout[31], item.vout} + {item.vd[31], item.vd};
  assign vid    = {item.vin[31], item.vin} + {item.vd[31], item.vd};
  assign vod64  = {{31{vod[32]}}, vod};
  assign vin64  = {{32{item.vin[31]}}, item.vin};
  assign prod64 = prod[63:0];

  always_comb begin
    unique case (item.phase)
      2'd0:    inv_l = cfg.inv_l_a;
      2'd1:    inv_l = cfg.inv_l_b;
      default: inv_l = cfg.inv_l_c;
    endcase
  end

  // operand select for the shared signed 34x34 multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      OP_INIT: begin
        ma = {3'b0, item.rl};
        mb = {{2{item.il[31]}}, item.il};
      end
      OP_T1: begin
        if (cfg.mode == MODE_BUCK) begin
          ma = {vid[32], vid};
          mb = {17'b0, item.duty};
        end else begin
          ma = {vod[32], vod};
          mb = {{16{omd[17]}}, omd};
        end
      end
      OP_T2: begin
        ma = {{2{item.il[31]}}, item.il};
        mb = {{16{omd[17]}}, omd};
      end
      OP_W0: begin
        ma = {2'b0, wa[31:0]};
        mb = {2'b0, wb[31:0]};
      end
      OP_W1: begin
        ma = {2'b0, wa[63:32]};
        mb = {2'b0, wb[31:0]};
      end
      OP_W2: begin
        ma = {2'b0, wa[31:0]};
        mb = {18'b0, wb[47:32]};
      end
      OP_W3: begin
        ma = {2'b0, wa[63:32]};
        mb = {18'b0, wb[47:32]};
      end
      default: ;
    endcase
  end

  // output-current share: il*(1-d) for boost, rounded half away from zero; il for buck
  always_comb begin
    pmag   = prod[67] ? $unsigned(-prod) : $unsigned(prod);
    pround = 34'((pmag[49:0] + 50'd32768) >> 16);
    if (cfg.mode == MODE_BUCK) begin
      contrib_next = {{3{item.il[31]}}, item.il};
    end else if (prod[67]) begin
      contrib_next = -$signed({1'b0, pround});
    end else begin
      contrib_next = $signed({1'b0, pround});
    end
  end

  assign nmag    = num[63] ? $unsigned(-num) : $unsigned(num);
  assign sum_add = {sum[47], sum} + {{14{contrib[34]}}, contrib};
  assign dv      = {sum[47], sum} - {{17{item.iout[31]}}, item.iout};
  assign dmag    = dv[48] ? $unsigned(-dv) : $unsigned(dv);

  // round the magnitude product, shift 32 for current and 16 for voltage
  always_comb begin
    fin_v  = (cmd.op == OP_FIN_V);
    rsum   = {1'b0, wacc} + (fin_v ? 113'd32768 : 113'h8000_0000);
    rshift = fin_v ? (rsum >> 16) : (rsum >> 32);
    rlim   = wneg ? 113'h8000_0000_0000 : 113'h7fff_ffff_ffff;
    rover  = (rshift > rlim);
    if (rover) begin
      rval = wneg ? NEG48 : POS48;
    end else begin
      rval = wneg ? (48'd0 - rshift[47:0]) : rshift[47:0];
    end
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    if (cmd.capture) begin
      item <= in_item;
    end
    unique case (cmd.op)
      OP_INIT: begin
        if (cfg.mode == MODE_BUCK) begin
          num <= -(vod64 <<< 16);
        end else begin
          num <= vin64 <<< 16;
        end
      end
      OP_T1: num <= num - prod64;
      OP_T2: begin
        if (cfg.mode == MODE_BUCK) begin
          num <= num + prod64;
        end else begin
          num <= num - prod64;
        end
      end
      OP_RND: begin
        contrib <= contrib_next;
        wa      <= nmag;
        wb      <= inv_l;
        wneg    <= num[63];
      end
      OP_W1: wacc <= {48'b0, prod[63:0]};
      OP_W2: wacc <= wacc + ({48'b0, prod[63:0]} << 32);
      OP_W3: wacc <= wacc + ({48'b0, prod[63:0]} << 32);
      OP_W4: wacc <= wacc + ({48'b0, prod[63:0]} << 64);
      OP_FIN_I: begin
        islope <= rval;
        vslope <= '0;
        sat    <= rover;
      end
      OP_VLOAD: begin
        wa   <= {15'b0, dmag};
        wb   <= cfg.inv_c;
        wneg <= dv[48];
      end
      OP_FIN_V: begin
        vslope <= rval;
        sat    <= sat | rover;
      end
      default: ;
    endcase
    if (cmd.load_out) begin
      res.phase  <= item.phase;
      res.islope <= islope;
      res.vslope <= vslope;
      res.last   <= item.last;
      res.sat    <= sat;
    end
  end

  // running output-current sum, clamped, cleared once the last phase is used
  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (cmd.op == OP_ACC) begin
      if (sum_add[48] != sum_add[47]) begin
        sum <= sum_add[48] ? NEG48 : POS48;
      end else begin
        sum <= sum_add[47:0];
      end
    end else if (cmd.op == OP_VLOAD) begin
      sum <= '0;
    end
  end

endmodule

### src/converter_state_derivatives_top.sv
`timescale 1ns / 1ps

// Averaged-model slope unit for an interleaved three-phase boost or buck converter.
// Each input transfer describes one phase; the unit answers with that phase's inductor
// current slope (signed Q32.16) and, on the transfer marked tlast, the output voltage
// slope from the accumulated phase currents minus the load current. Items with phase 3
// are dropped without a result. The single shared 34x34 multiplier forms the numerator
// terms and then the 64x48 product with 1/L (and 1/C on the last phase) as four partial
// products. A finished result sits in an output register, so the next item is accepted
// while it waits. The user must write configuration through the APB port only while
// the unit is idle; the block itself does not enforce this.

module converter_state_derivatives_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [csd_pkg::PADDR_W-1:0]   paddr,
  input  logic [csd_pkg::PDATA_W-1:0]   pwdata,
  output logic [csd_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // input_voltage, output_voltage, load_current, phase_current, duty_ratio,
  // winding_resistance, diode_drop
  input  logic [csd_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // phase
  input  logic [1:0]                    s_axis_tuser,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // current_slope, voltage_slope
  output logic [csd_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // phase_out, saturated
  output logic [2:0]                    m_axis_tuser,
  output logic                          m_axis_tlast
);
  import csd_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;
  item_t in_item;
  res_t  res;

  assign in_item.phase = s_axis_tuser;
  assign in_item.last  = s_axis_tlast;
  assign in_item.vin   = s_axis_tdata[31:0];
  assign in_item.vout  = s_axis_tdata[63:32];
  assign in_item.iout  = s_axis_tdata[95:64];
  assign in_item.il    = s_axis_tdata[127:96];
  assign in_item.duty  = s_axis_tdata[144:128];
  assign in_item.rl    = s_axis_tdata[175:145];
  assign in_item.vd    = s_axis_tdata[207:176];

  assign m_axis_tdata = {res.vslope, res.islope};
  assign m_axis_tuser = {res.sat, res.phase};
  assign m_axis_tlast = res.last;

  csd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  csd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  csd_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .cfg     (cfg),
    .in_item (in_item),
    .res     (res)
  );

endmodule
